// ----- hdl/y2rgb_pkg.sv -----
// ----------------------------------------------------------------------------
// y2rgb_pkg
// Shared constants, types and helpers of the YCbCr to RGB group converter.
// ----------------------------------------------------------------------------
package y2rgb_pkg;

  // Pixels in one group
  localparam int unsigned Lanes     = 8;
  // Width of the pixel count field
  localparam int unsigned CountW    = 4;
  // Register stages between the input and the output transfer
  localparam int unsigned NumStages = 4;

  localparam int unsigned CoefW = 18;  // signed coefficient width
  localparam int unsigned OffW  = 9;   // signed chroma offset width
  localparam int unsigned ProdW = 27;  // signed product width, |product| < 2^24
  localparam int unsigned TermW = 11;  // signed chroma term width
  localparam int unsigned SumW  = 12;  // signed luma plus term width

  localparam logic signed [OffW-1:0] ChromaMid = 9'sd128;

  // Vector path, 14-bit coefficients, floor then times four
  localparam logic signed [CoefW-1:0] CoefRCrVec = 18'sd22970;
  localparam logic signed [CoefW-1:0] CoefGCbVec = 18'sd5638;
  localparam logic signed [CoefW-1:0] CoefGCrVec = 18'sd11700;
  localparam logic signed [CoefW-1:0] CoefBCbVec = 18'sd29032;

  // Scalar path, 16-bit coefficients with rounding
  localparam logic signed [CoefW-1:0] CoefRCrSca = 18'sd91881;
  localparam logic signed [CoefW-1:0] CoefGCbSca = 18'sd22554;
  localparam logic signed [CoefW-1:0] CoefGCrSca = 18'sd46802;
  localparam logic signed [CoefW-1:0] CoefBCbSca = 18'sd116130;

  localparam logic signed [ProdW-1:0] RoundBias = 27'sd32768;

  // Per-stage load strobes from the pipeline control
  typedef struct packed {
    logic [NumStages-1:0] load;
  } stage_ctrl_t;

  // Saturate a signed sum to 0..255
  function automatic logic [7:0] clamp_byte(input logic signed [SumW-1:0] v);
    logic [7:0] res;
    if (v[SumW-1]) begin
      res = 8'd0;
    end else if (v > 12'sd255) begin
      res = 8'd255;
    end else begin
      res = v[7:0];
    end
    return res;
  endfunction

endpackage

// ----- hdl/y2rgb_if.sv -----
// ----------------------------------------------------------------------------
// y2rgb_in_if / y2rgb_out_if
// Valid/ready channels carrying a pixel group in and the RGB group out.
// ----------------------------------------------------------------------------
interface y2rgb_in_if #(
  parameter int unsigned LANES = y2rgb_pkg::Lanes
);
  logic                            valid;
  logic                            ready;
  logic [8*LANES-1:0]              luma_bytes;
  logic [8*LANES-1:0]              blue_chroma_bytes;
  logic [8*LANES-1:0]              red_chroma_bytes;
  logic [y2rgb_pkg::CountW-1:0]    valid_lanes;
  logic                            row_end;

  modport source (
    output valid, luma_bytes, blue_chroma_bytes, red_chroma_bytes, valid_lanes, row_end,
    input  ready
  );
  modport sink (
    input  valid, luma_bytes, blue_chroma_bytes, red_chroma_bytes, valid_lanes, row_end,
    output ready
  );
endinterface

interface y2rgb_out_if #(
  parameter int unsigned LANES = y2rgb_pkg::Lanes
);
  logic               valid;
  logic               ready;
  logic [8*LANES-1:0] red_bytes;
  logic [8*LANES-1:0] green_bytes;
  logic [8*LANES-1:0] blue_bytes;
  logic               row_done;

  modport source (
    output valid, red_bytes, green_bytes, blue_bytes, row_done,
    input  ready
  );
  modport sink (
    input  valid, red_bytes, green_bytes, blue_bytes, row_done,
    output ready
  );
endinterface

// ----- hdl/y2rgb_ctrl.sv -----
// ----------------------------------------------------------------------------
// y2rgb_ctrl
// Valid tracking and per-stage load strobes for the converter pipeline.
// ----------------------------------------------------------------------------
module y2rgb_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output y2rgb_pkg::stage_ctrl_t ctrl_o
);

  localparam int unsigned N = y2rgb_pkg::NumStages;

  logic [N-1:0] vld_q, vld_d;
  logic [N-1:0] rdy;   // stage can take a new item this cycle
  logic [N-1:0] load;

  always_comb begin
    rdy[N-1] = !vld_q[N-1] || out_ready_i;
    for (int k = N - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
    load[0] = in_valid_i && rdy[0];
    for (int k = 1; k < N; k++) begin
      load[k] = vld_q[k-1] && rdy[k];
    end
    for (int k = 0; k < N; k++) begin
      vld_d[k] = rdy[k] ? load[k] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[N-1];
  assign ctrl_o.load = load;

endmodule

// ----- hdl/y2rgb_lane.sv -----
// ----------------------------------------------------------------------------
// y2rgb_lane
// One pixel lane: offset, multiply, scale/round, add and clamp, four stages.
// ----------------------------------------------------------------------------
module y2rgb_lane (
  input  logic                   clk_i,
  input  y2rgb_pkg::stage_ctrl_t ctrl_i,
  input  logic [7:0]             luma_i,
  input  logic [7:0]             cb_i,
  input  logic [7:0]             cr_i,
  input  logic                   lane_on_i,
  input  logic                   vec_i,
  output logic [7:0]             red_o,
  output logic [7:0]             green_o,
  output logic [7:0]             blue_o
);

  localparam int unsigned OffW  = y2rgb_pkg::OffW;
  localparam int unsigned CoefW = y2rgb_pkg::CoefW;
  localparam int unsigned ProdW = y2rgb_pkg::ProdW;
  localparam int unsigned TermW = y2rgb_pkg::TermW;
  localparam int unsigned SumW  = y2rgb_pkg::SumW;

  // stage 1: operands
  logic [7:0]             y1_q;
  logic signed [OffW-1:0] cb1_q, cr1_q;
  logic                   on1_q, vec1_q;
  // stage 2: products
  logic [7:0]              y2_q;
  logic signed [ProdW-1:0] pr_q, pgb_q, pgr_q, pb_q;
  logic                    on2_q, vec2_q;
  // stage 3: chroma terms
  logic [7:0]              y3_q;
  logic signed [TermW-1:0] tr_q, tg_q, tb_q;
  logic                    on3_q;
  // stage 4: clamped bytes
  logic [7:0] r4_q, g4_q, b4_q;

  logic signed [CoefW-1:0] c_r, c_gb, c_gr, c_b;
  logic signed [ProdW-1:0] pr_d, pgb_d, pgr_d, pb_d;
  logic signed [ProdW-1:0] rnd_r, rnd_g, rnd_b;
  logic signed [TermW-1:0] gv_sum;
  logic signed [TermW-1:0] tr_d, tg_d, tb_d;
  logic signed [SumW-1:0]  sr, sg, sb;

  // Coefficient set follows the formula of the group
  always_comb begin
    c_r  = vec1_q ? y2rgb_pkg::CoefRCrVec : y2rgb_pkg::CoefRCrSca;
    c_gb = vec1_q ? y2rgb_pkg::CoefGCbVec : y2rgb_pkg::CoefGCbSca;
    c_gr = vec1_q ? y2rgb_pkg::CoefGCrVec : y2rgb_pkg::CoefGCrSca;
    c_b  = vec1_q ? y2rgb_pkg::CoefBCbVec : y2rgb_pkg::CoefBCbSca;
    pr_d  = cr1_q * c_r;
    pgb_d = cb1_q * c_gb;
    pgr_d = cr1_q * c_gr;
    pb_d  = cb1_q * c_b;
  end

  // Vector: floor(p / 2^16) * 4 per term. Scalar: floor((p + 2^15) / 2^16).
  always_comb begin
    rnd_r  = pr_q + y2rgb_pkg::RoundBias;
    rnd_g  = pgb_q + pgr_q + y2rgb_pkg::RoundBias;
    rnd_b  = pb_q + y2rgb_pkg::RoundBias;
    gv_sum = pgb_q[ProdW-1:16] + pgr_q[ProdW-1:16];
    if (vec2_q) begin
      tr_d = {pr_q[TermW+13:16], 2'b00};
      tg_d = {gv_sum[TermW-3:0], 2'b00};
      tb_d = {pb_q[TermW+13:16], 2'b00};
    end else begin
      tr_d = rnd_r[ProdW-1:16];
      tg_d = rnd_g[ProdW-1:16];
      tb_d = rnd_b[ProdW-1:16];
    end
  end

  always_comb begin
    sr = $signed({4'b0000, y3_q}) + {tr_q[TermW-1], tr_q};
    sg = $signed({4'b0000, y3_q}) - {tg_q[TermW-1], tg_q};
    sb = $signed({4'b0000, y3_q}) + {tb_q[TermW-1], tb_q};
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[0]) begin
      y1_q   <= luma_i;
      cb1_q  <= $signed({1'b0, cb_i}) - y2rgb_pkg::ChromaMid;
      cr1_q  <= $signed({1'b0, cr_i}) - y2rgb_pkg::ChromaMid;
      on1_q  <= lane_on_i;
      vec1_q <= vec_i;
    end
    if (ctrl_i.load[1]) begin
      y2_q   <= y1_q;
      pr_q   <= pr_d;
      pgb_q  <= pgb_d;
      pgr_q  <= pgr_d;
      pb_q   <= pb_d;
      on2_q  <= on1_q;
      vec2_q <= vec1_q;
    end
    if (ctrl_i.load[2]) begin
      y3_q  <= y2_q;
      tr_q  <= tr_d;
      tg_q  <= tg_d;
      tb_q  <= tb_d;
      on3_q <= on2_q;
    end
    if (ctrl_i.load[3]) begin
      r4_q <= on3_q ? y2rgb_pkg::clamp_byte(sr) : 8'd0;
      g4_q <= on3_q ? y2rgb_pkg::clamp_byte(sg) : 8'd0;
      b4_q <= on3_q ? y2rgb_pkg::clamp_byte(sb) : 8'd0;
    end
  end

  assign red_o   = r4_q;
  assign green_o = g4_q;
  assign blue_o  = b4_q;

endmodule

// ----- hdl/ycbcr_to_rgb_group_converter_core.sv -----
// ----------------------------------------------------------------------------
// ycbcr_to_rgb_group_converter_core
// Full-range BT.601 YCbCr to RGB, one group of up to eight pixels per transfer.
// ----------------------------------------------------------------------------
// Pipeline: four register stages; with the output taken, a group moves through
//   them in turn and shows on the output from the last one.
// Throughput: one group per cycle; a stalled output backs up stage by stage,
//   and empty stages are filled while the output waits.
// Reset: rst_ni (async, active low) clears the stage valid bits only.
// ----------------------------------------------------------------------------
module ycbcr_to_rgb_group_converter_core #(
  parameter int unsigned LANES = y2rgb_pkg::Lanes
) (
  input logic         clk_i,
  input logic         rst_ni,
  y2rgb_in_if.sink    in_i,
  y2rgb_out_if.source out_o
);

  localparam int unsigned N      = y2rgb_pkg::NumStages;
  localparam int unsigned CountW = y2rgb_pkg::CountW;

  y2rgb_pkg::stage_ctrl_t ctrl;

  // Count of LANES or more picks the vector formula for every lane;
  // fewer picks the rounding formula for the lanes present.
  logic         vec;
  logic [N-1:0] row_q;

  assign vec = (in_i.valid_lanes >= CountW'(LANES));

  // Valid bits and load strobes; the datapath follows the strobes.
  y2rgb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .ctrl_o      (ctrl)
  );

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    logic on;
    // Lanes at or above the count stay zero
    assign on = vec || (in_i.valid_lanes > CountW'(i));

    y2rgb_lane u_lane (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl),
      .luma_i    (in_i.luma_bytes[8*i +: 8]),
      .cb_i      (in_i.blue_chroma_bytes[8*i +: 8]),
      .cr_i      (in_i.red_chroma_bytes[8*i +: 8]),
      .lane_on_i (on),
      .vec_i     (vec),
      .red_o     (out_o.red_bytes[8*i +: 8]),
      .green_o   (out_o.green_bytes[8*i +: 8]),
      .blue_o    (out_o.blue_bytes[8*i +: 8])
    );
  end

  // Row-end flag rides alongside the lanes
  always_ff @(posedge clk_i) begin
    if (ctrl.load[0]) begin
      row_q[0] <= in_i.row_end;
    end
    for (int k = 1; k < N; k++) begin
      if (ctrl.load[k]) begin
        row_q[k] <= row_q[k-1];
      end
    end
  end

  assign out_o.row_done = row_q[N-1];

endmodule

// ----- hdl/y2rgb_chk.sv -----
// ----------------------------------------------------------------------------
// y2rgb_chk
// Port-level checks of the converter, bound to the top level.
// ----------------------------------------------------------------------------
module y2rgb_chk #(
  parameter int unsigned LANES = y2rgb_pkg::Lanes
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic [y2rgb_pkg::CountW-1:0] in_count_i,
  input logic                         in_row_end_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [8*LANES-1:0]           out_red_i,
  input logic [8*LANES-1:0]           out_green_i,
  input logic [8*LANES-1:0]           out_blue_i,
  input logic                         out_row_done_i
);

  logic in_xfer;
  assign in_xfer = in_valid_i && in_ready_i;

  // A waiting result holds still
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_red_i)
      && $stable(out_green_i) && $stable(out_blue_i) && $stable(out_row_done_i))
    else $error("output changed while stalled");

  // Input backpressure only when every stage is full and the output stalls
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled with room in the pipeline");

  // With the output kept ready, a group reaches the output with its row-end flag
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i |=>
      out_valid_i && (out_row_done_i == $past(in_row_end_i, 4)))
    else $error("group lost or row flag mismatch");

  // An empty group gives all-zero colors
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && (in_count_i == '0) ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i
      |=> (out_red_i == '0) && (out_green_i == '0) && (out_blue_i == '0))
    else $error("empty group gave nonzero color");

endmodule

bind ycbcr_to_rgb_group_converter_core y2rgb_chk #(
  .LANES (LANES)
) u_y2rgb_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .in_count_i     (in_i.valid_lanes),
  .in_row_end_i   (in_i.row_end),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_red_i      (out_o.red_bytes),
  .out_green_i    (out_o.green_bytes),
  .out_blue_i     (out_o.blue_bytes),
  .out_row_done_i (out_o.row_done)
);
